// File: hw/rtl/attitude_complementary_filter_top_macros.svh
// Assertion macros used by the attitude filter checker.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in the using scope.
`ifndef ATTITUDE_COMPLEMENTARY_FILTER_TOP_MACROS_SVH
`define ATTITUDE_COMPLEMENTARY_FILTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ACF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ACF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/acf_pkg.sv
// Package for the attitude complementary filter: types, fixed-point constants and microcode.
// Used by acf_sequencer, acf_datapath and the top level; depends on nothing.
package acf_pkg;

    localparam int STEP_W = 4;

    // Fixed-point constants: Q0.16 multipliers, Q4.12 angles.
    localparam logic signed [16:0] DT_Q16     = 17'sd655;
    localparam logic signed [16:0] INV_G_Q16  = 17'sd6685;
    localparam logic signed [16:0] NINV_G_Q16 = -17'sd6685;
    localparam logic signed [15:0] PI_Q12     = 16'sd12868;
    localparam logic signed [16:0] TWO_PI_Q12 = 17'sd25736;
    localparam logic [15:0]        WEIGHT_RST = 16'd64225;

    typedef enum logic [2:0] {
        MA_ZERO, MA_GX, MA_GY, MA_GZ, MA_AX, MA_AY, MA_DROLL, MA_DPITCH
    } t_mul_a;

    typedef enum logic [1:0] {
        MB_DT, MB_INVG, MB_NINVG, MB_WEIGHT
    } t_mul_b;

    typedef enum logic [2:0] {
        PO_NONE, PO_ROLL_G, PO_PITCH_G, PO_YAW, PO_ROLL_A, PO_PITCH_A, PO_ROLL_B, PO_PITCH_B
    } t_post;

    typedef enum logic [1:0] {
        CD_ALWAYS, CD_IN_VALID, CD_OUT_FREE
    } t_cond;

    typedef struct packed {
        t_mul_a            mul_a;
        t_mul_b            mul_b;
        t_post             post;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uop;

    typedef struct packed {
        t_mul_a mul_a;
        t_mul_b mul_b;
        t_post  post;
        logic   load_in;
        logic   emit;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } t_stat;

    localparam logic [STEP_W-1:0] STEP_WAIT = 4'd0;

    // Each step multiplies into the product register and post-processes the product
    // of the step before. A step holds until its condition is met, then goes to target.
    function automatic t_uop ucode_rom(input logic [STEP_W-1:0] addr);
        t_uop u;
        u = '{MA_ZERO, MB_DT, PO_NONE, CD_ALWAYS, STEP_WAIT};
        unique case (addr)
            4'd0: u = '{MA_ZERO,   MB_DT,     PO_NONE,    CD_IN_VALID, 4'd1};
            4'd1: u = '{MA_GX,     MB_DT,     PO_NONE,    CD_ALWAYS,   4'd2};
            4'd2: u = '{MA_GY,     MB_DT,     PO_ROLL_G,  CD_ALWAYS,   4'd3};
            4'd3: u = '{MA_GZ,     MB_DT,     PO_PITCH_G, CD_ALWAYS,   4'd4};
            4'd4: u = '{MA_AY,     MB_INVG,   PO_YAW,     CD_ALWAYS,   4'd5};
            4'd5: u = '{MA_AX,     MB_NINVG,  PO_ROLL_A,  CD_ALWAYS,   4'd6};
            4'd6: u = '{MA_DROLL,  MB_WEIGHT, PO_PITCH_A, CD_ALWAYS,   4'd7};
            4'd7: u = '{MA_DPITCH, MB_WEIGHT, PO_ROLL_B,  CD_ALWAYS,   4'd8};
            4'd8: u = '{MA_ZERO,   MB_DT,     PO_PITCH_B, CD_ALWAYS,   4'd9};
            4'd9: u = '{MA_ZERO,   MB_DT,     PO_NONE,    CD_OUT_FREE, STEP_WAIT};
            default: u = '{MA_ZERO, MB_DT, PO_NONE, CD_ALWAYS, STEP_WAIT};
        endcase
        return u;
    endfunction

endpackage

// File: hw/rtl/acf_sequencer.sv
// Microcode sequencer: step counter, control store lookup and conditional branching.
// Depends on acf_pkg.
module acf_sequencer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  acf_pkg::t_stat i_stat,
    output acf_pkg::t_ctrl o_ctrl,
    output logic           o_in_ready
);
    import acf_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uop              uop;
    logic              go;

    assign uop = ucode_rom(r_step);

    always_comb begin
        unique case (uop.cond)
            CD_ALWAYS:   go = 1'b1;
            CD_IN_VALID: go = i_stat.in_valid;
            CD_OUT_FREE: go = i_stat.out_free;
            default:     go = 1'b1;
        endcase
    end

    always_comb begin
        n_step = go ? uop.target : r_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    // No request is taken while reset is held.
    always_comb begin
        o_ctrl.mul_a   = uop.mul_a;
        o_ctrl.mul_b   = uop.mul_b;
        o_ctrl.post    = go ? uop.post : PO_NONE;
        o_ctrl.load_in = (uop.cond == CD_IN_VALID) && i_stat.in_valid;
        o_ctrl.emit    = (uop.cond == CD_OUT_FREE) && i_stat.out_free;
        o_in_ready     = (uop.cond == CD_IN_VALID) && i_rst_n;
    end

endmodule

// File: hw/rtl/acf_datapath.sv
// Filter datapath: input latch, shared multiplier, round/saturate/wrap unit, angle state
// and output register. Depends on acf_pkg; steered by acf_sequencer.
module acf_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  acf_pkg::t_ctrl i_ctrl,
    input  logic [95:0]    i_in_data,
    input  logic           i_cfg_wr_en,
    input  logic [15:0]    i_cfg_wr_data,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic [47:0]    o_out_data,
    output logic           o_out_free
);
    import acf_pkg::*;

    logic signed [15:0] r_ax, r_ay, r_gx, r_gy, r_gz;
    logic [15:0]        r_weight;
    logic signed [15:0] r_roll, r_pitch, r_yaw;
    logic signed [15:0] r_roll_g, r_pitch_g, r_roll_a, r_pitch_a;
    logic signed [33:0] r_prod;
    logic               r_out_valid;
    logic [47:0]        r_out_data;

    logic signed [16:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [35:0] addend;
    logic signed [35:0] rnd;
    logic signed [35:0] sum;
    logic signed [35:0] sum_sh;
    logic signed [15:0] sat_v;
    logic signed [16:0] wrap_v;
    logic signed [15:0] post_v;
    logic               use16;
    logic               do_wrap;

    always_comb begin
        unique case (i_ctrl.mul_a)
            MA_ZERO:   mul_a = '0;
            MA_GX:     mul_a = {r_gx[15], r_gx};
            MA_GY:     mul_a = {r_gy[15], r_gy};
            MA_GZ:     mul_a = {r_gz[15], r_gz};
            MA_AX:     mul_a = {r_ax[15], r_ax};
            MA_AY:     mul_a = {r_ay[15], r_ay};
            MA_DROLL:  mul_a = {r_roll_g[15], r_roll_g} - {r_roll_a[15], r_roll_a};
            MA_DPITCH: mul_a = {r_pitch_g[15], r_pitch_g} - {r_pitch_a[15], r_pitch_a};
            default:   mul_a = '0;
        endcase
        unique case (i_ctrl.mul_b)
            MB_DT:     mul_b = DT_Q16;
            MB_INVG:   mul_b = INV_G_Q16;
            MB_NINVG:  mul_b = NINV_G_Q16;
            MB_WEIGHT: mul_b = $signed({1'b0, r_weight});
            default:   mul_b = DT_Q16;
        endcase
    end

    // The blend a*g + (1-a)*acc is formed as acc*2^16 + a*(g-acc), so one product
    // per angle suffices. Gyro integration folds the old angle in at 2^12.
    always_comb begin
        use16   = 1'b0;
        do_wrap = 1'b0;
        addend  = '0;
        unique case (i_ctrl.post)
            PO_ROLL_G:  addend = 36'(r_roll)  <<< 12;
            PO_PITCH_G: addend = 36'(r_pitch) <<< 12;
            PO_YAW: begin
                addend  = 36'(r_yaw) <<< 12;
                do_wrap = 1'b1;
            end
            PO_ROLL_B: begin
                addend  = 36'(r_roll_a) <<< 16;
                use16   = 1'b1;
                do_wrap = 1'b1;
            end
            PO_PITCH_B: begin
                addend  = 36'(r_pitch_a) <<< 16;
                use16   = 1'b1;
                do_wrap = 1'b1;
            end
            default: addend = '0;
        endcase
        rnd    = use16 ? 36'sd32768 : 36'sd2048;
        sum    = addend + 36'(r_prod) + rnd;
        sum_sh = use16 ? (sum >>> 16) : (sum >>> 12);
        if (sum_sh > 36'sd32767) begin
            sat_v = 16'sh7fff;
        end else if (sum_sh < -36'sd32768) begin
            sat_v = -16'sh8000;
        end else begin
            sat_v = sum_sh[15:0];
        end
        wrap_v = {sat_v[15], sat_v};
        if (do_wrap && (sat_v > PI_Q12)) begin
            wrap_v = wrap_v - TWO_PI_Q12;
        end else if (do_wrap && (sat_v < -PI_Q12)) begin
            wrap_v = wrap_v + TWO_PI_Q12;
        end
        post_v = wrap_v[15:0];
    end

    assign o_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (i_ctrl.load_in) begin
            r_ax <= i_in_data[15:0];
            r_ay <= i_in_data[31:16];
            r_gx <= i_in_data[63:48];
            r_gy <= i_in_data[79:64];
            r_gz <= i_in_data[95:80];
        end
        unique case (i_ctrl.post)
            PO_ROLL_G:  r_roll_g  <= post_v;
            PO_PITCH_G: r_pitch_g <= post_v;
            PO_ROLL_A:  r_roll_a  <= post_v;
            PO_PITCH_A: r_pitch_a <= post_v;
            default: ;
        endcase
        if (i_ctrl.emit) begin
            r_out_data <= {r_yaw, r_pitch, r_roll};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll      <= '0;
            r_pitch     <= '0;
            r_yaw       <= '0;
            r_weight    <= WEIGHT_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_weight <= i_cfg_wr_data;
            end
            unique case (i_ctrl.post)
                PO_YAW:     r_yaw   <= post_v;
                PO_ROLL_B:  r_roll  <= post_v;
                PO_PITCH_B: r_pitch <= post_v;
                default: ;
            endcase
            if (i_ctrl.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: hw/rtl/attitude_complementary_filter_top.sv
// Top level of the attitude complementary filter.
// Depends on acf_pkg, acf_sequencer and acf_datapath.
//
// Usage: one IMU sample enters per request on the s_axis channel, and one request with
// the updated roll, pitch and yaw angles (signed Q4.12 radians) leaves on m_axis.
// The gyro weight of the blend is written through i_cfg_wr_en / i_cfg_wr_data while
// the block is idle; a write takes effect at the clock edge where the enable is high.
//
// Sequence: the microcode program spends one step to take the sample, seven steps
// through the single shared 17 x 17 multiplier, one step to finish the last blend and
// one to load the output register, which then presents the result request. A new
// sample is taken only once the program is back at its first step.
//
// Reset (i_rst_n low at a clock edge) clears the three angles to zero, restores the
// gyro weight to 64225 and drops m_axis_tvalid; s_axis_tready stays low while reset
// is held. When the receiver stalls, the result waits in the output register and the
// next sample is still taken and processed; the sequencer only holds at its final step
// until the output register is free again.
module attitude_complementary_filter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Sample input channel.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0 up: accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 each).
    input  logic [95:0] s_axis_tdata,
    // Result output channel.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0 up: roll_out, pitch_out, yaw_out (16 each).
    output logic [47:0] m_axis_tdata,
    // Gyro blend weight register, unsigned Q0.16.
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);
    import acf_pkg::*;

    t_ctrl ctrl;
    t_stat stat;
    logic  out_free;

    // The sequencer sees the input request and whether the output register can load.
    always_comb begin
        stat.in_valid = s_axis_tvalid;
        stat.out_free = out_free;
    end

    acf_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (stat),
        .o_ctrl     (ctrl),
        .o_in_ready (s_axis_tready)
    );

    // All arithmetic and the angle state live in the datapath.
    acf_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_in_data     (s_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_data    (m_axis_tdata),
        .o_out_free    (out_free)
    );

endmodule

// File: hw/rtl/acf_checker.sv
// Port-level assertions for the attitude complementary filter, bound to the top level.
// Depends on attitude_complementary_filter_top_macros.svh.
`include "attitude_complementary_filter_top_macros.svh"

module acf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    logic out_stall;
    logic in_take;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign in_take   = s_axis_tvalid && s_axis_tready;

    // A stalled result stays offered.
    `ACF_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid, "result dropped while stalled")

    // A stalled result keeps its value.
    `ACF_ASSERT_NXT(a_out_stable, out_stall, $stable(m_axis_tdata), "stalled result changed")

    // Only one sample is in work at a time.
    `ACF_ASSERT_NXT(a_one_in_flight, in_take, !s_axis_tready, "sample taken during work")

    // A result appears only from the final step, when no sample is being taken.
    `ACF_ASSERT_IMP(a_emit_step, $rose(m_axis_tvalid), !$past(s_axis_tready),
                    "result raised outside the final step")

endmodule

bind attitude_complementary_filter_top acf_checker u_acf_checker (.*);
